// ----- sv/i2crw_pkg.sv -----
package i2crw_pkg;

  localparam int unsigned AddrW  = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD_TICKS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT_TICKS = 2'd2;

  localparam logic [AddrW-1:0] DEVICE_ADDRESS_RST    = 7'd60;
  localparam logic [ByteW-1:0] HALF_PERIOD_TICKS_RST = 8'd2;
  localparam logic [ByteW-1:0] ACK_TIMEOUT_TICKS_RST = 8'd250;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_START_A  = 10'b00_0000_0010,
    PH_START_B  = 10'b00_0000_0100,
    PH_BIT_LOW  = 10'b00_0000_1000,
    PH_BIT_HIGH = 10'b00_0001_0000,
    PH_ACK_LOW  = 10'b00_0010_0000,
    PH_ACK_HIGH = 10'b00_0100_0000,
    PH_STOP_A   = 10'b00_1000_0000,
    PH_STOP_B   = 10'b01_0000_0000,
    PH_STOP_C   = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [AddrW-1:0] device_address;
    logic [ByteW-1:0] half_period_ticks;
    logic [ByteW-1:0] ack_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic done_res;
    logic ack_error;
    logic request_refused;
  } result_t;

endpackage

// ----- sv/i2crw_cfg.sv -----
module i2crw_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [i2crw_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [i2crw_pkg::ByteW-1:0]    wr_data,
  output i2crw_pkg::cfg_t                cfg
);
  import i2crw_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address    <= DEVICE_ADDRESS_RST;
      cfg_r.half_period_ticks <= HALF_PERIOD_TICKS_RST;
      cfg_r.ack_timeout_ticks <= ACK_TIMEOUT_TICKS_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DEVICE_ADDRESS:    cfg_r.device_address    <= wr_data[AddrW-1:0];
        CFG_HALF_PERIOD_TICKS: cfg_r.half_period_ticks <= wr_data;
        CFG_ACK_TIMEOUT_TICKS: cfg_r.ack_timeout_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/i2crw_seq.sv -----
module i2crw_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic                        action,
  input  logic [i2crw_pkg::ByteW-1:0] control_byte,
  input  logic [i2crw_pkg::ByteW-1:0] data_byte,
  input  logic                        sda_sampled,
  input  i2crw_pkg::cfg_t             cfg,
  output i2crw_pkg::result_t          res
);
  import i2crw_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] byte_index_r, byte_index_nxt;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] shift_out_r, shift_out_nxt;
  logic [7:0] held_control_r, held_control_nxt;
  logic [7:0] held_data_r, held_data_nxt;
  logic [7:0] tick_count_r, tick_count_nxt;
  logic [7:0] ack_wait_r, ack_wait_nxt;
  logic       error_flag_r, error_flag_nxt;

  logic [7:0] tc_inc;
  logic [7:0] limit;
  logic       hold_end;
  logic [3:0] bc_inc;
  logic [1:0] bi_inc;
  logic       scl, sda;

  assign tc_inc   = tick_count_r + 8'd1;
  assign limit    = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
  assign hold_end = tc_inc >= limit;
  assign bc_inc   = bit_count_r + 4'd1;
  assign bi_inc   = byte_index_r + 2'd1;

  always_comb begin
    case (phase_r)
      PH_START_A:  begin scl = 1'b1; sda = 1'b1;           end
      PH_START_B:  begin scl = 1'b1; sda = 1'b0;           end
      PH_BIT_LOW:  begin scl = 1'b0; sda = shift_out_r[7]; end
      PH_BIT_HIGH: begin scl = 1'b1; sda = shift_out_r[7]; end
      PH_ACK_LOW:  begin scl = 1'b0; sda = 1'b1;           end
      PH_ACK_HIGH: begin scl = 1'b1; sda = 1'b1;           end
      PH_STOP_A:   begin scl = 1'b0; sda = 1'b0;           end
      PH_STOP_B:   begin scl = 1'b1; sda = 1'b0;           end
      PH_STOP_C:   begin scl = 1'b1; sda = 1'b1;           end
      default:     begin scl = 1'b1; sda = 1'b1;           end
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    byte_index_nxt   = byte_index_r;
    bit_count_nxt    = bit_count_r;
    shift_out_nxt    = shift_out_r;
    held_control_nxt = held_control_r;
    held_data_nxt    = held_data_r;
    tick_count_nxt   = tick_count_r;
    ack_wait_nxt     = ack_wait_r;
    error_flag_nxt   = error_flag_r;
    res              = '0;
    res.scl_level    = 1'b1;
    res.sda_level    = 1'b1;

    if (!action) begin
      if (phase_r != PH_IDLE) begin
        res.request_refused = 1'b1;
        res.scl_level       = scl;
        res.sda_level       = sda;
      end else begin
        held_control_nxt = control_byte;
        held_data_nxt    = data_byte;
        byte_index_nxt   = 2'd0;
        bit_count_nxt    = 4'd0;
        shift_out_nxt    = 8'd0;
        tick_count_nxt   = 8'd0;
        ack_wait_nxt     = 8'd0;
        error_flag_nxt   = 1'b0;
        phase_nxt        = PH_START_A;
      end
    end else begin
      res.scl_level = scl;
      res.sda_level = sda;
      case (phase_r)
        PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH,
        PH_ACK_LOW, PH_STOP_A, PH_STOP_B, PH_STOP_C: begin
          tick_count_nxt = hold_end ? 8'd0 : tc_inc;
        end
        default: ;
      endcase
      case (phase_r)
        PH_START_A: begin
          if (hold_end) phase_nxt = PH_START_B;
        end
        PH_START_B: begin
          if (hold_end) begin
            shift_out_nxt  = {cfg.device_address, 1'b0};
            byte_index_nxt = 2'd0;
            bit_count_nxt  = 4'd0;
            phase_nxt      = PH_BIT_LOW;
          end
        end
        PH_BIT_LOW: begin
          if (hold_end) phase_nxt = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          if (hold_end) begin
            shift_out_nxt = {shift_out_r[6:0], 1'b0};
            if (bc_inc >= 4'd8) begin
              bit_count_nxt = 4'd0;
              phase_nxt     = PH_ACK_LOW;
            end else begin
              bit_count_nxt = bc_inc;
              phase_nxt     = PH_BIT_LOW;
            end
          end
        end
        PH_ACK_LOW: begin
          if (hold_end) begin
            ack_wait_nxt = 8'd0;
            phase_nxt    = PH_ACK_HIGH;
          end
        end
        PH_ACK_HIGH: begin
          if (!sda_sampled) begin
            ack_wait_nxt   = 8'd0;
            tick_count_nxt = 8'd0;
            byte_index_nxt = bi_inc;
            if (bi_inc == 2'd1) begin
              shift_out_nxt = held_control_r;
              phase_nxt     = PH_BIT_LOW;
            end else if (bi_inc == 2'd2) begin
              shift_out_nxt = held_data_r;
              phase_nxt     = PH_BIT_LOW;
            end else begin
              phase_nxt = PH_STOP_A;
            end
          end else if (ack_wait_r >= cfg.ack_timeout_ticks) begin
            error_flag_nxt = 1'b1;
            ack_wait_nxt   = 8'd0;
            tick_count_nxt = 8'd0;
            phase_nxt      = PH_STOP_A;
          end else begin
            ack_wait_nxt = ack_wait_r + 8'd1;
          end
        end
        PH_STOP_A: begin
          if (hold_end) phase_nxt = PH_STOP_B;
        end
        PH_STOP_B: begin
          if (hold_end) phase_nxt = PH_STOP_C;
        end
        PH_STOP_C: begin
          if (hold_end) begin
            res.done_res  = 1'b1;
            res.ack_error = error_flag_r;
            phase_nxt     = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    res.busy_res = phase_nxt != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      byte_index_r   <= 2'd0;
      bit_count_r    <= 4'd0;
      shift_out_r    <= 8'd0;
      held_control_r <= 8'd0;
      held_data_r    <= 8'd0;
      tick_count_r   <= 8'd0;
      ack_wait_r     <= 8'd0;
      error_flag_r   <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      byte_index_r   <= byte_index_nxt;
      bit_count_r    <= bit_count_nxt;
      shift_out_r    <= shift_out_nxt;
      held_control_r <= held_control_nxt;
      held_data_r    <= held_data_nxt;
      tick_count_r   <= tick_count_nxt;
      ack_wait_r     <= ack_wait_nxt;
      error_flag_r   <= error_flag_nxt;
    end
  end

endmodule

// ----- sv/i2c_register_write_master.sv -----
// I2C master that writes one device register: a request beat (action 0) latches a
// control byte and a data byte, and each tick beat (action 1) steps SCL/SDA through
// start, address+write, ack, control byte, ack, data byte, ack, stop. Every input
// beat yields exactly one result beat carrying the line drive for that tick plus
// busy, done, ack_error and request_refused flags. One beat is accepted per clock
// while out_stall does not hold a valid result; a beat passes the input register,
// then the sequencer step into the result register, one state update per beat.
// Configuration writes are always ready and are meant to happen while idle.
module i2c_register_write_master (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [i2crw_pkg::ByteW-1:0]   in_control_byte,
  input  logic [i2crw_pkg::ByteW-1:0]   in_data_byte,
  input  logic                          in_sda_sampled,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_scl_level,
  output logic                          out_sda_level,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_ack_error,
  output logic                          out_request_refused,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [i2crw_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [i2crw_pkg::ByteW-1:0]   cfg_data
);
  import i2crw_pkg::*;

  logic             in_vld_r;
  logic             action_r;
  logic [ByteW-1:0] control_byte_r;
  logic [ByteW-1:0] data_byte_r;
  logic             sda_sampled_r;
  logic             out_vld_r;
  result_t          res_r;
  result_t          step_res;
  cfg_t             cfg;
  logic             advance;
  logic             in_take;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_take   = in_valid && !in_stall;

  i2crw_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  i2crw_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .action       (action_r),
    .control_byte (control_byte_r),
    .data_byte    (data_byte_r),
    .sda_sampled  (sda_sampled_r),
    .cfg          (cfg),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r       <= in_action;
      control_byte_r <= in_control_byte;
      data_byte_r    <= in_data_byte;
      sda_sampled_r  <= in_sda_sampled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_scl_level       = res_r.scl_level;
  assign out_sda_level       = res_r.sda_level;
  assign out_busy_res        = res_r.busy_res;
  assign out_done_res        = res_r.done_res;
  assign out_ack_error       = res_r.ack_error;
  assign out_request_refused = res_r.request_refused;

endmodule
